>>> src/dtok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtok_pkg
// Shared types, constants and keyword ROM for the BASIC detokenizer.
// ----------------------------------------------------------------------------
package dtok_pkg;

    localparam int          CNT_W      = 16;
    localparam int          TEXT_W     = 56;     // longest keyword is 7 chars
    localparam logic [7:0]  TOK_BASE   = 8'h80;
    localparam logic [7:0]  TOK_END    = 8'hEB;  // first unknown token
    localparam logic [7:0]  CH_NEWLINE = 8'h0A;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // configuration register indexes
    localparam logic CFG_LIMIT_ON   = 1'b0;
    localparam logic CFG_CHAR_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        MODE_CHAR,
        MODE_NUMBER,
        MODE_KEYWORD,
        MODE_STATUS
    } t_mode;

    // one unit of work for the back end: nchar characters, then an
    // optional end-of-stream status result
    typedef struct packed {
        t_mode             mode;
        logic [15:0]       value;   // char, line number or token index
        logic [2:0]        nchar;
        logic              stop;
        logic              hit;
        logic [CNT_W-1:0]  count;   // character count before this item
    } t_cmd;

    typedef struct packed {
        logic  valid;
        t_cmd  cmd;
    } t_push;

    function automatic logic [2:0] num_digits(input logic [15:0] v);
        logic [2:0] n;
        if (v >= 16'd10000)     n = 3'd5;
        else if (v >= 16'd1000) n = 3'd4;
        else if (v >= 16'd100)  n = 3'd3;
        else if (v >= 16'd10)   n = 3'd2;
        else                    n = 3'd1;
        return n;
    endfunction

    function automatic logic [16:0] pow10(input logic [2:0] p);
        logic [16:0] r;
        case (p)
            3'd1:    r = 17'd10;
            3'd2:    r = 17'd100;
            3'd3:    r = 17'd1000;
            3'd4:    r = 17'd10000;
            default: r = 17'd1;
        endcase
        return r;
    endfunction

    // keyword text, right-justified, first character in the highest used byte
    function automatic logic [TEXT_W-1:0] kw_text(input logic [6:0] idx);
        logic [TEXT_W-1:0] t;
        case (idx)
            7'd0:   t = "END";      7'd1:   t = "FOR";      7'd2:   t = "NEXT";
            7'd3:   t = "DATA";     7'd4:   t = "INPUT";    7'd5:   t = "DEL";
            7'd6:   t = "DIM";      7'd7:   t = "READ";     7'd8:   t = "GR";
            7'd9:   t = "TEXT";     7'd10:  t = "PR#";      7'd11:  t = "IN#";
            7'd12:  t = "CALL";     7'd13:  t = "PLOT";     7'd14:  t = "HLIN";
            7'd15:  t = "VLIN";     7'd16:  t = "HGR2";     7'd17:  t = "HGR";
            7'd18:  t = "HCOLOR=";  7'd19:  t = "HPLOT";    7'd20:  t = "DRAW";
            7'd21:  t = "XDRAW";    7'd22:  t = "HTAB";     7'd23:  t = "HOME";
            7'd24:  t = "ROT=";     7'd25:  t = "SCALE=";   7'd26:  t = "SHLOAD";
            7'd27:  t = "TRACE";    7'd28:  t = "NOTRACE";  7'd29:  t = "NORMAL";
            7'd30:  t = "INVERSE";  7'd31:  t = "FLASH";    7'd32:  t = "COLOR=";
            7'd33:  t = "POP";      7'd34:  t = "VTAB";     7'd35:  t = "HIMEM:";
            7'd36:  t = "LOMEM:";   7'd37:  t = "ONERR";    7'd38:  t = "RESUME";
            7'd39:  t = "RECALL";   7'd40:  t = "STORE";    7'd41:  t = "SPEED=";
            7'd42:  t = "LET";      7'd43:  t = "GOTO";     7'd44:  t = "RUN";
            7'd45:  t = "IF";       7'd46:  t = "RESTORE";  7'd47:  t = "&";
            7'd48:  t = "GOSUB";    7'd49:  t = "RETURN";   7'd50:  t = "REM";
            7'd51:  t = "STOP";     7'd52:  t = "ON";       7'd53:  t = "WAIT";
            7'd54:  t = "LOAD";     7'd55:  t = "SAVE";     7'd56:  t = "DEF";
            7'd57:  t = "POKE";     7'd58:  t = "PRINT";    7'd59:  t = "CONT";
            7'd60:  t = "LIST";     7'd61:  t = "CLEAR";    7'd62:  t = "GET";
            7'd63:  t = "NEW";      7'd64:  t = "TAB(";     7'd65:  t = "TO";
            7'd66:  t = "FN";       7'd67:  t = "SPC(";     7'd68:  t = "THEN";
            7'd69:  t = "AT";       7'd70:  t = "NOT";      7'd71:  t = "STEP";
            7'd72:  t = "+";        7'd73:  t = "-";        7'd74:  t = "*";
            7'd75:  t = "/";        7'd76:  t = "^";        7'd77:  t = "AND";
            7'd78:  t = "OR";       7'd79:  t = ">";        7'd80:  t = "=";
            7'd81:  t = "<";        7'd82:  t = "SGN";      7'd83:  t = "INT";
            7'd84:  t = "ABS";      7'd85:  t = "USR";      7'd86:  t = "FRE";
            7'd87:  t = "SCRN(";    7'd88:  t = "PDL";      7'd89:  t = "POS";
            7'd90:  t = "SQR";      7'd91:  t = "RND";      7'd92:  t = "LOG";
            7'd93:  t = "EXP";      7'd94:  t = "COS";      7'd95:  t = "SIN";
            7'd96:  t = "TAN";      7'd97:  t = "ATN";      7'd98:  t = "PEEK";
            7'd99:  t = "LEN";      7'd100: t = "STR$";     7'd101: t = "VAL";
            7'd102: t = "ASC";      7'd103: t = "CHR$";     7'd104: t = "LEFT$";
            7'd105: t = "RIGHT$";   7'd106: t = "MID$";
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [6:0] idx);
        logic [TEXT_W-1:0] t;
        logic [2:0]        n;
        t = kw_text(idx);
        n = 3'd0;
        for (int i = 0; i < TEXT_W / 8; i++) begin
            if (t[8*i +: 8] != 8'h00) n = n + 3'd1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> src/basic_token_detokenizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// basic_token_detokenizer_top
// Tokenized BASIC program bytes in, listing text characters out.
// ----------------------------------------------------------------------------
// Throughput: one result per cycle from the back end while the sink is ready;
// an item that finds the back end idle is loaded before it emits. Input takes
// an item every cycle while the 4-entry command queue has room; link bytes and
// the low line-number byte queue no command unless a zero link ends the stream.
// Reset (synchronous, active low) clears parse state, count, queue and
// output valid; limit_on resets to 0 and char_limit to 65535.
// ----------------------------------------------------------------------------
module basic_token_detokenizer_top
    import dtok_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_stream_start,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_char,
    output logic                   o_char_valid,
    output logic                   o_last,
    output logic                   o_finished,
    output logic                   o_limit_hit,
    output logic [CNT_W-1:0]       o_chars_emitted
);

    logic              r_limit_on;
    logic [CNT_W-1:0]  r_char_limit;
    logic              accept;
    t_push             push;
    t_cmd              head;
    logic              q_empty, q_full, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_on   <= 1'b0;
            r_char_limit <= CNT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIMIT_ON:   r_limit_on   <= i_cfg_data[0];
                CFG_CHAR_LIMIT: r_char_limit <= i_cfg_data;
                default:        r_limit_on   <= r_limit_on;
            endcase
        end
    end

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    dtok_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_stream_start (i_stream_start),
        .i_limit_on     (r_limit_on),
        .i_char_limit   (r_char_limit),
        .o_push         (push)
    );

    dtok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dtok_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_char      (o_out_char),
        .o_char_valid    (o_char_valid),
        .o_last          (o_last),
        .o_finished      (o_finished),
        .o_limit_hit     (o_limit_hit),
        .o_chars_emitted (o_chars_emitted)
    );

endmodule
`default_nettype wire

>>> src/dtok_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtok_front
// Parses link / line-number / body bytes, tracks the character count and
// limit, and issues one command per byte that yields results.
// ----------------------------------------------------------------------------
module dtok_front
    import dtok_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_stream_start,
    input  wire logic              i_limit_on,
    input  wire logic [CNT_W-1:0]  i_char_limit,
    output t_push                  o_push
);

    typedef enum logic [2:0] {
        PH_LINK_LO,
        PH_LINK_HI,
        PH_LINE_LO,
        PH_LINE_HI,
        PH_BODY,
        PH_END_LINK,
        PH_END_LIMIT
    } t_phase;

    t_phase            r_phase, n_phase, eff_phase;
    logic [7:0]        r_line_lo, n_line_lo, eff_line_lo;
    logic              r_link_nz, n_link_nz, eff_link_nz;
    logic [CNT_W-1:0]  r_count, n_count, eff_count;
    logic              r_done, n_done, eff_done;

    logic              push;
    t_cmd              cmd;
    logic              has_chars;
    logic [2:0]        need;
    logic [CNT_W-1:0]  avail;
    logic              stop;
    logic [2:0]        take;
    logic [CNT_W:0]    sum;
    logic [15:0]       line_num;

    always_comb begin
        eff_phase   = i_stream_start ? PH_LINK_LO : r_phase;
        eff_line_lo = i_stream_start ? 8'h00 : r_line_lo;
        eff_link_nz = i_stream_start ? 1'b0 : r_link_nz;
        eff_count   = i_stream_start ? '0 : r_count;
        eff_done    = i_stream_start ? 1'b0 : r_done;

        n_phase   = eff_phase;
        n_line_lo = eff_line_lo;
        n_link_nz = eff_link_nz;
        n_count   = eff_count;
        n_done    = eff_done;

        line_num   = {i_data_byte, eff_line_lo};
        push       = 1'b0;
        has_chars  = 1'b0;
        need       = 3'd0;
        cmd        = '0;
        cmd.mode   = MODE_STATUS;
        cmd.count  = eff_count;

        if (eff_done) begin
            // repeat how the stream ended
            push    = 1'b1;
            cmd.stop = 1'b1;
            cmd.hit  = (eff_phase == PH_END_LIMIT);
        end else begin
            case (eff_phase)
                PH_LINK_LO: begin
                    n_link_nz = (i_data_byte != 8'h00);
                    n_phase   = PH_LINK_HI;
                end
                PH_LINK_HI: begin
                    if (!eff_link_nz && i_data_byte == 8'h00) begin
                        n_done   = 1'b1;
                        n_phase  = PH_END_LINK;
                        push     = 1'b1;
                        cmd.stop = 1'b1;
                    end else begin
                        n_phase = PH_LINE_LO;
                    end
                end
                PH_LINE_LO: begin
                    n_line_lo = i_data_byte;
                    n_phase   = PH_LINE_HI;
                end
                PH_LINE_HI: begin
                    n_phase   = PH_BODY;
                    has_chars = 1'b1;
                    need      = num_digits(line_num) + 3'd1;   // digits and a space
                    cmd.mode  = MODE_NUMBER;
                    cmd.value = line_num;
                end
                PH_BODY: begin
                    if (i_data_byte == 8'h00) begin
                        has_chars = 1'b1;
                        need      = 3'd1;
                        cmd.mode  = MODE_CHAR;
                        cmd.value = {8'h00, CH_NEWLINE};
                        n_phase   = PH_LINK_LO;
                    end else if (i_data_byte < TOK_BASE) begin
                        has_chars = 1'b1;
                        need      = 3'd1;
                        cmd.mode  = MODE_CHAR;
                        cmd.value = {8'h00, i_data_byte};
                    end else if (i_data_byte < TOK_END) begin
                        has_chars = 1'b1;
                        need      = kw_len(7'(i_data_byte - TOK_BASE));
                        cmd.mode  = MODE_KEYWORD;
                        cmd.value = {9'h000, 7'(i_data_byte - TOK_BASE)};
                    end
                end
                default: begin
                    // ended phases without the done flag, and the unused code
                    n_done   = 1'b1;
                    n_phase  = PH_END_LINK;
                    push     = 1'b1;
                    cmd.stop = 1'b1;
                end
            endcase
        end

        // limit: emit what still fits, then stop
        avail = (eff_count < i_char_limit) ? (i_char_limit - eff_count) : '0;
        stop  = i_limit_on && (avail < {{(CNT_W-3){1'b0}}, need});
        take  = stop ? avail[2:0] : need;
        sum   = {1'b0, eff_count} + {{(CNT_W-2){1'b0}}, need};

        if (has_chars) begin
            push      = 1'b1;
            cmd.nchar = take;
            cmd.stop  = stop;
            cmd.hit   = stop;
            if (stop) begin
                n_count = eff_count + {{(CNT_W-3){1'b0}}, take};
                n_done  = 1'b1;
                n_phase = PH_END_LIMIT;
            end else begin
                n_count = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LINK_LO;
            r_line_lo <= 8'h00;
            r_link_nz <= 1'b0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_line_lo <= n_line_lo;
            r_link_nz <= n_link_nz;
            r_count   <= n_count;
            r_done    <= n_done;
        end
    end

    assign o_push.valid = i_accept && push;
    assign o_push.cmd   = cmd;

endmodule
`default_nettype wire

>>> src/dtok_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtok_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module dtok_queue
    import dtok_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    input  wire logic   i_pop,
    output t_cmd        o_head,
    output logic        o_empty,
    output logic        o_full
);

    t_cmd               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QPTR_W:0]    r_cnt;
    logic               do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/dtok_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtok_back
// Expands one command into characters (plain, decimal line number or keyword)
// plus an optional status result: one result per cycle when the output is free.
// ----------------------------------------------------------------------------
module dtok_back
    import dtok_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_char,
    output logic                   o_char_valid,
    output logic                   o_last,
    output logic                   o_finished,
    output logic                   o_limit_hit,
    output logic [CNT_W-1:0]       o_chars_emitted
);

    logic               r_busy;
    t_mode              r_mode;
    logic [2:0]         r_rem;
    logic               r_stop;
    logic               r_hit;
    logic [CNT_W-1:0]   r_count;
    logic [TEXT_W-1:0]  r_text;
    logic [2:0]         r_sel;     // keyword byte or decimal position
    logic [15:0]        r_num;     // remaining line-number value
    logic               r_numsp;   // digits done, space next

    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_char_valid, r_last, r_fin, r_hit_out;
    logic [CNT_W-1:0]   r_out_cnt;

    logic               slot_free, emit, is_char, finishing;
    logic [7:0]         ch;
    logic [16:0]        pw;
    logic [3:0]         dig;
    logic [16:0]        sub;
    logic [CNT_W-1:0]   cnt_inc;
    logic [2:0]         ld_len;

    assign slot_free = !r_out_valid || i_out_ready;
    assign emit      = r_busy && slot_free;
    assign is_char   = (r_rem != 3'd0);
    assign finishing = emit && (is_char ? (r_rem == 3'd1 && !r_stop) : 1'b1);
    assign o_pop     = !i_empty && (!r_busy || finishing);
    assign cnt_inc   = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
    assign ld_len    = kw_len(i_head.value[6:0]);

    // leading digit by compare against multiples of the current power of ten
    always_comb begin
        pw  = pow10(r_sel);
        dig = 4'd0;
        sub = 17'd0;
        for (int m = 1; m <= 9; m++) begin
            if ({1'b0, r_num} >= 17'(m) * pw) begin
                dig = 4'(m);
                sub = 17'(m) * pw;
            end
        end
    end

    always_comb begin
        case (r_mode)
            MODE_NUMBER:  ch = r_numsp ? CH_SPACE : CH_ZERO + {4'h0, dig};
            MODE_KEYWORD: ch = r_text[{r_sel, 3'b000} +: 8];
            default:      ch = r_text[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (finishing) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char   <= is_char ? ch : 8'h00;
            r_char_valid <= is_char;
            r_last       <= finishing;
            r_fin        <= !is_char;
            r_hit_out    <= !is_char && r_hit;
            r_out_cnt    <= is_char ? cnt_inc : r_count;
        end

        if (o_pop) begin
            r_mode  <= i_head.mode;
            r_rem   <= i_head.nchar;
            r_stop  <= i_head.stop;
            r_hit   <= i_head.hit;
            r_count <= i_head.count;
            r_num   <= i_head.value;
            r_numsp <= 1'b0;
            case (i_head.mode)
                MODE_NUMBER: begin
                    r_text <= '0;
                    r_sel  <= num_digits(i_head.value) - 3'd1;
                end
                MODE_KEYWORD: begin
                    r_text <= kw_text(i_head.value[6:0]);
                    r_sel  <= ld_len - 3'd1;
                end
                default: begin
                    r_text <= {{(TEXT_W-8){1'b0}}, i_head.value[7:0]};
                    r_sel  <= 3'd0;
                end
            endcase
        end else if (emit && is_char) begin
            r_rem   <= r_rem - 3'd1;
            r_count <= cnt_inc;
            if (r_mode == MODE_NUMBER && !r_numsp) begin
                r_num <= r_num - sub[15:0];
                if (r_sel == 3'd0) r_numsp <= 1'b1;
                else               r_sel   <= r_sel - 3'd1;
            end else if (r_mode == MODE_KEYWORD) begin
                r_sel <= r_sel - 3'd1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_char_valid    = r_char_valid;
    assign o_last          = r_last;
    assign o_finished      = r_fin;
    assign o_limit_hit     = r_hit_out;
    assign o_chars_emitted = r_out_cnt;

endmodule
`default_nettype wire

>>> tb/sv/basic_token_detokenizer_top_tb.sv
// ----------------------------------------------------------------------------
// basic_token_detokenizer_top_tb
// Feeds tokenized BASIC program images through the detokenizer, predicts the
// listing text, count and end-of-stream status for every byte, and checks
// each output item against that prediction under random source and sink
// stalls. Directed streams cover the extremes, then random programs run
// under several limit settings.
// ----------------------------------------------------------------------------
module basic_token_detokenizer_top_tb;
    import dtok_pkg::*;

    // parse phases
    localparam logic [2:0] PH_LINK_LO   = 3'd0;
    localparam logic [2:0] PH_LINK_HI   = 3'd1;
    localparam logic [2:0] PH_LINE_LO   = 3'd2;
    localparam logic [2:0] PH_LINE_HI   = 3'd3;
    localparam logic [2:0] PH_BODY      = 3'd4;
    localparam logic [2:0] PH_END_LINK  = 3'd5;
    localparam logic [2:0] PH_END_LIMIT = 3'd6;

    localparam int MAX_PER_BYTE = 8;
    localparam int TAIL_CYCLES  = 10;

    typedef struct packed {
        logic [7:0] b;
        logic       st;
    } t_prog_byte;

    typedef struct packed {
        logic [7:0]       ch;
        logic             is_char;
        logic             lst;
        logic             fin;
        logic             hit;
        logic [CNT_W-1:0] cnt;
    } t_text_res;

    string kw_names [0:106] = '{
        "END", "FOR", "NEXT", "DATA", "INPUT", "DEL", "DIM", "READ",
        "GR", "TEXT", "PR#", "IN#", "CALL", "PLOT", "HLIN", "VLIN",
        "HGR2", "HGR", "HCOLOR=", "HPLOT", "DRAW", "XDRAW", "HTAB", "HOME",
        "ROT=", "SCALE=", "SHLOAD", "TRACE", "NOTRACE", "NORMAL", "INVERSE", "FLASH",
        "COLOR=", "POP", "VTAB", "HIMEM:", "LOMEM:", "ONERR", "RESUME", "RECALL",
        "STORE", "SPEED=", "LET", "GOTO", "RUN", "IF", "RESTORE", "&",
        "GOSUB", "RETURN", "REM", "STOP", "ON", "WAIT", "LOAD", "SAVE",
        "DEF", "POKE", "PRINT", "CONT", "LIST", "CLEAR", "GET", "NEW",
        "TAB(", "TO", "FN", "SPC(", "THEN", "AT", "NOT", "STEP",
        "+", "-", "*", "/", "^", "AND", "OR", ">",
        "=", "<", "SGN", "INT", "ABS", "USR", "FRE", "SCRN(",
        "PDL", "POS", "SQR", "RND", "LOG", "EXP", "COS", "SIN",
        "TAN", "ATN", "PEEK", "LEN", "STR$", "VAL", "ASC", "CHR$",
        "LEFT$", "RIGHT$", "MID$"
    };

    logic             i_clk;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_LIMIT_ON;
    logic [15:0]      cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic [7:0]       data_byte = '0;
    logic             stream_start = 1'b0;
    logic             out_ready = 1'b0;

    logic             o_in_ready;
    logic             o_out_valid;
    logic [7:0]       o_out_char;
    logic             o_char_valid;
    logic             o_last;
    logic             o_finished;
    logic             o_limit_hit;
    logic [CNT_W-1:0] o_chars_emitted;

    basic_token_detokenizer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (data_byte),
        .i_stream_start  (stream_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_out_char      (o_out_char),
        .o_char_valid    (o_char_valid),
        .o_last          (o_last),
        .o_finished      (o_finished),
        .o_limit_hit     (o_limit_hit),
        .o_chars_emitted (o_chars_emitted)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 1000000);
        $display("basic_token_detokenizer_top_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Listing predictor
    // ------------------------------------------------------------------
    logic             lim_en  = 1'b0;
    logic [15:0]      lim_val = CNT_MAX;
    logic [2:0]       ph      = PH_LINK_LO;
    logic [7:0]       line_lo = '0;
    logic             link_lo_nz = 1'b0;
    logic [CNT_W-1:0] n_out   = '0;
    logic             done    = 1'b0;

    t_text_res  byte_text[$];   // items caused by the byte being predicted
    t_text_res  text_exp[$];    // items still owed by the block
    t_prog_byte prog_bytes[$];  // bytes waiting for the source side
    int         queued_cnt = 0;
    int         fail_cnt   = 0;
    bit         src_idle_en = 1'b1;
    bit         snk_idle_en = 1'b1;

    function automatic void add_text(logic [7:0] ch, logic is_char, logic fin, logic hit);
        if (byte_text.size() < MAX_PER_BYTE)
            byte_text.push_back('{ch: ch, is_char: is_char, lst: 1'b0, fin: fin, hit: hit,
                                  cnt: n_out});
    endfunction

    // returns 0 when the limit stopped the stream instead
    function automatic bit put_ch(logic [7:0] ch);
        if (lim_en && n_out >= lim_val) begin
            done = 1'b1;
            ph = PH_END_LIMIT;
            add_text(8'h00, 1'b0, 1'b1, 1'b1);
            return 1'b0;
        end
        if (n_out != CNT_MAX) n_out = n_out + 1'b1;
        add_text(ch, 1'b1, 1'b0, 1'b0);
        return 1'b1;
    endfunction

    function automatic void put_line_num(logic [15:0] v);
        logic [7:0] dig [5];
        int         nd;
        nd = 0;
        do begin
            dig[nd] = CH_ZERO + 8'(v % 16'd10);
            v = v / 16'd10;
            nd++;
        end while (v != 16'd0);
        for (int i = nd - 1; i >= 0; i--)
            if (!put_ch(dig[i])) return;
        void'(put_ch(CH_SPACE));
    endfunction

    function automatic void put_body(logic [7:0] b);
        string kw;
        if (b == 8'h00) begin
            if (put_ch(CH_NEWLINE)) ph = PH_LINK_LO;
            return;
        end
        if (b < TOK_BASE) begin
            void'(put_ch(b));
            return;
        end
        if (b >= TOK_END) return;  // unknown token is dropped
        kw = kw_names[b - TOK_BASE];
        for (int i = 0; i < kw.len(); i++)
            if (!put_ch(kw[i])) return;
    endfunction

    function automatic void detokenize_byte(logic [7:0] b, logic st);
        byte_text.delete();
        if (st) begin
            ph = PH_LINK_LO;
            line_lo = '0;
            link_lo_nz = 1'b0;
            n_out = '0;
            done = 1'b0;
        end
        if (done) begin
            add_text(8'h00, 1'b0, 1'b1, ph == PH_END_LIMIT);
        end else begin
            case (ph)
                PH_LINK_LO: begin
                    link_lo_nz = (b != 8'h00);
                    ph = PH_LINK_HI;
                end
                PH_LINK_HI: begin
                    if (!link_lo_nz && b == 8'h00) begin
                        done = 1'b1;
                        ph = PH_END_LINK;
                        add_text(8'h00, 1'b0, 1'b1, 1'b0);
                    end else begin
                        ph = PH_LINE_LO;
                    end
                end
                PH_LINE_LO: begin
                    line_lo = b;
                    ph = PH_LINE_HI;
                end
                PH_LINE_HI: begin
                    ph = PH_BODY;
                    put_line_num({b, line_lo});
                end
                PH_BODY: begin
                    put_body(b);
                end
                default: begin
                    done = 1'b1;
                    ph = PH_END_LINK;
                    add_text(8'h00, 1'b0, 1'b1, 1'b0);
                end
            endcase
        end
        if (byte_text.size() > 0) byte_text[byte_text.size() - 1].lst = 1'b1;
        foreach (byte_text[i]) text_exp.push_back(byte_text[i]);
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        logic       nxt_valid;
        t_prog_byte it;
        int         src_wait;
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_wait = 0;
        end else begin
            nxt_valid = in_valid;
            if (in_valid && o_in_ready) begin
                detokenize_byte(data_byte, stream_start);
                nxt_valid = 1'b0;
                src_wait = src_idle_en ? $urandom_range(0, 7) : 0;
            end
            if (!nxt_valid) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (prog_bytes.size() > 0) begin
                    it = prog_bytes.pop_front();
                    data_byte    <= it.b;
                    stream_start <= it.st;
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Sink side and checker
    // ------------------------------------------------------------------
    function automatic void flag_bad(string why, t_text_res got, t_text_res want);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display({"%s: got char=%h cv=%b last=%b fin=%b hit=%b cnt=%0d",
                      " | exp char=%h cv=%b last=%b fin=%b hit=%b cnt=%0d"},
                     why, got.ch, got.is_char, got.lst, got.fin, got.hit, got.cnt,
                     want.ch, want.is_char, want.lst, want.fin, want.hit, want.cnt);
    endfunction

    always @(posedge i_clk) begin : watch
        t_text_res got;
        t_text_res want;
        int        snk_wait;
        if (!rst_n) begin
            out_ready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                got = '{ch: o_out_char, is_char: o_char_valid, lst: o_last,
                        fin: o_finished, hit: o_limit_hit, cnt: o_chars_emitted};
                if (text_exp.size() == 0) begin
                    flag_bad("unexpected item", got, '0);
                end else begin
                    want = text_exp.pop_front();
                    if (got != want) flag_bad("mismatch", got, want);
                end
                snk_wait = snk_idle_en ? $urandom_range(0, 7) : 0;
            end
            if (snk_wait > 0) begin
                snk_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Program generation
    // ------------------------------------------------------------------
    function automatic void queue_byte(logic [7:0] b, logic st);
        prog_bytes.push_back('{b: b, st: st});
        queued_cnt++;
    endfunction

    function automatic void queue_line(bit first);
        logic [15:0] num;
        int          sel;
        // link with a zero low byte must still continue when the high byte is set
        if ($urandom_range(0, 4) == 0) begin
            queue_byte(8'h00, first);
            queue_byte(8'($urandom_range(1, 255)), 1'b0);
        end else begin
            queue_byte(8'($urandom_range(1, 255)), first);
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        case ($urandom_range(0, 3))
            0: num = 16'($urandom_range(0, 9));
            1: num = 16'($urandom_range(10, 999));
            2: num = 16'($urandom_range(0, 65535));
            default: num = $urandom_range(0, 1) ? CNT_MAX : 16'd10000;
        endcase
        queue_byte(num[7:0], 1'b0);
        queue_byte(num[15:8], 1'b0);
        repeat ($urandom_range(0, 6)) begin
            sel = $urandom_range(0, 9);
            if (sel < 5)      queue_byte(8'($urandom_range(1, 127)), 1'b0);
            else if (sel < 9) queue_byte(8'($urandom_range(128, 234)), 1'b0);
            else              queue_byte(8'($urandom_range(235, 255)), 1'b0);
        end
        queue_byte(8'h00, 1'b0);
    endfunction

    // sampled on the falling edge so that the source side has settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (prog_bytes.size() != 0 || in_valid || text_exp.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limit(logic on, logic [15:0] lim);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LIMIT_ON;
        cfg_data  <= {15'd0, on};
        lim_en = on;
        @(posedge i_clk);
        cfg_index <= CFG_CHAR_LIMIT;
        cfg_data  <= lim;
        lim_val = lim;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(logic on, logic [15:0] lim, int n);
        int stop_at;
        set_limit(on, lim);
        src_idle_en = $urandom_range(0, 3) != 0;
        snk_idle_en = $urandom_range(0, 3) != 0;
        stop_at = queued_cnt + n;
        while (queued_cnt < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                // noise, now and then with a restart in the middle
                repeat ($urandom_range(1, 6))
                    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                queue_line(1'b1);
                repeat ($urandom_range(0, 2)) queue_line(1'b0);
                if ($urandom_range(0, 6) != 0) begin
                    queue_byte(8'h00, 1'b0);
                    queue_byte(8'h00, 1'b0);
                end
                repeat ($urandom_range(0, 2)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        wait_drained();
    endtask

    initial begin : stimulus
        // line 0 with edge tokens, comparison tokens and unknown tokens,
        // line 65535 behind a link with a zero low byte, zero link, one byte past the end
        logic [7:0] demo [22] = '{
            8'h01, 8'h08, 8'h00, 8'h00,
            8'h80, 8'hEA, 8'hCF, 8'hD0, 8'hD1, 8'hEB, 8'hFF, 8'h7F, 8'h01, 8'h00,
            8'h00, 8'h09, 8'hFF, 8'hFF, 8'h00,
            8'h00, 8'h00,
            8'h55
        };

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        set_limit(1'b0, CNT_MAX);
        foreach (demo[i]) queue_byte(demo[i], i == 0);
        wait_drained();

        // zero limit stops on the first digit, next byte repeats the stop
        set_limit(1'b1, 16'd0);
        queue_byte(8'h01, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h05, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h41, 1'b0);
        wait_drained();

        random_phase(1'b0, 16'($urandom_range(0, 65535)), 60);
        random_phase(1'b1, 16'($urandom_range(1, 40)), 60);
        random_phase(1'b1, 16'd0, 30);
        random_phase(1'b1, CNT_MAX, 60);
        random_phase(1'b1, 16'($urandom_range(40, 200)), 60);
        random_phase(1'b0, CNT_MAX, 20);

        if (fail_cnt == 0) begin
            $display("basic_token_detokenizer_top_tb OK");
        end else begin
            $display("basic_token_detokenizer_top_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
src/dtok_pkg.sv
src/dtok_front.sv
src/dtok_queue.sv
src/dtok_back.sv
src/basic_token_detokenizer_top.sv
tb/sv/basic_token_detokenizer_top_tb.sv
